@@ design/drct_pkg.sv @@
`timescale 1ns / 1ps

package drct_pkg;

  localparam int unsigned CHANNELS_DEF = 8;

  // Reply command bytes and frame limits
  localparam logic [7:0] CMD_SENSOR     = 8'h1D;
  localparam logic [7:0] CMD_CIS        = 8'h5B;
  localparam logic [7:0] CMD_CB         = 8'h5F;
  localparam logic [7:0] BYTE_ZERO      = 8'h00;
  localparam logic [7:0] BYTE_END       = 8'hFF;
  localparam logic [7:0] SENSOR_MIN_LEN = 8'd7;
  localparam logic [7:0] CALIB_MIN_LEN  = 8'd6;

  // Calibration status codes carried in frame byte 4
  localparam logic [7:0] STAT_RUNNING = 8'h01;
  localparam logic [7:0] STAT_SUCCESS = 8'h02;
  localparam logic [7:0] STAT_FAIL_IR = 8'h05;

  typedef enum logic [1:0] {
    ACT_REPLY = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_END   = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  typedef enum logic [3:0] {
    RC_INVALID  = 4'd0,
    RC_IGNORED  = 4'd1,
    RC_START    = 4'd2,
    RC_END      = 4'd3,
    RC_DATA     = 4'd4,
    RC_CALIB    = 4'd5,
    RC_BEGIN_OK = 4'd6,
    RC_BEGIN_NO = 4'd7,
    RC_DONE     = 4'd8
  } rc_e;

  localparam logic [2:0] CIS_IDLE    = 3'd0;
  localparam logic [2:0] CIS_RUNNING = 3'd1;

  localparam logic [1:0] CB_IDLE    = 2'd0;
  localparam logic [1:0] CB_RUNNING = 2'd1;
  localparam logic [1:0] CB_SUCCESS = 2'd2;
  localparam logic [1:0] CB_FAIL_IR = 2'd3;

  localparam logic [1:0] BEGIN_CIS = 2'd0;
  localparam logic [1:0] BEGIN_CB  = 2'd1;

  localparam logic TGT_CIS = 1'b0;
  localparam logic TGT_CB  = 1'b1;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] command_code;
    logic [7:0] frame_length;
    logic [7:0] index_or_status;
    logic [7:0] sample_value;
    logic [1:0] begin_target;
    logic [2:0] read_channel;
  } req_t;

  typedef struct packed {
    logic [3:0]  result_code;
    logic [2:0]  cis_status;
    logic [1:0]  cb_status;
    logic        active_target;
    logic        session_open;
    logic [15:0] update_tally;
    logic [7:0]  channel_raw;
    logic        channel_valid;
  } rsp_t;

  typedef struct packed {
    logic [2:0] cis;
    logic [1:0] cb;
    logic       target;
    logic       session;
  } cal_state_t;

  // Sensor store update for one step; addr is the zero-based channel
  typedef struct packed {
    logic       clear;
    logic       write;
    logic       bump;
    logic [7:0] addr;
    logic [7:0] data;
  } store_wr_t;

endpackage

@@ design/diag_reply_calibration_tracker.sv @@
`timescale 1ns / 1ps

// An accepted input waits in the input register and moves into the result register when that is free.
// Throughput: one item per cycle while the result is not stalled; decode is combinational.
// A stalled result holds the result register and the input register behind it.
// Reset (rst, synchronous): all channels invalid and reading zero, tally zero,
// both calibrations idle, target CIS, no session, both pipeline registers empty.
module diag_reply_calibration_tracker import drct_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic       s1_valid;
  req_t       s1_item;
  logic       advance;
  cal_state_t cal;
  cal_state_t cal_next;
  store_wr_t  wr;
  rc_e        rc;
  logic [3:0] rc_q;
  logic [15:0] tally;
  logic [7:0]  rd_raw;
  logic        rd_valid;

  assign advance   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  drct_decode #(
    .CHANNELS(CHANNELS)
  ) u_decode (
    .item     (s1_item),
    .cal      (cal),
    .cal_next (cal_next),
    .wr       (wr),
    .rc       (rc)
  );

  drct_store #(
    .CHANNELS(CHANNELS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .wr       (wr),
    .rd_ch    (s1_item.read_channel),
    .tally    (tally),
    .rd_raw   (rd_raw),
    .rd_valid (rd_valid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cal       <= '{cis: CIS_IDLE, cb: CB_IDLE, target: TGT_CIS, session: 1'b0};
      rc_q      <= RC_INVALID;
      rsp_valid <= 1'b0;
    end else begin
      if (advance) begin
        cal  <= cal_next;
        rc_q <= rc;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    rsp.result_code   = rc_q;
    rsp.cis_status    = cal.cis;
    rsp.cb_status     = cal.cb;
    rsp.active_target = cal.target;
    rsp.session_open  = cal.session;
    rsp.update_tally  = tally;
    rsp.channel_raw   = rd_raw;
    rsp.channel_valid = rd_valid;
  end

  assert property (@(posedge clk) disable iff (rst)
    !(cal.cis == CIS_RUNNING && cal.cb == CB_RUNNING))
    else $error("both calibrations running");

  assert property (@(posedge clk) disable iff (rst)
    (cal.cis == CIS_RUNNING || cal.cb == CB_RUNNING) |-> cal.session)
    else $error("calibration running outside a session");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_item)))
    else $error("held item dropped from input register");

  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(cal))
    else $error("calibration state moved without a step");

endmodule

@@ design/drct_decode.sv @@
`timescale 1ns / 1ps

module drct_decode import drct_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  req_t       item,
  input  cal_state_t cal,
  output cal_state_t cal_next,
  output store_wr_t  wr,
  output rc_e        rc
);

  localparam logic [7:0] LAST_IDX = 8'(CHANNELS);

  logic idx_zero;
  logic pair_end;
  logic idx_in_range;
  logic target_match;

  assign idx_zero     = (item.index_or_status == BYTE_ZERO) && (item.sample_value == BYTE_ZERO);
  assign pair_end     = (item.index_or_status == BYTE_END) && (item.sample_value == BYTE_END);
  assign idx_in_range = (item.index_or_status != BYTE_ZERO) && (item.index_or_status <= LAST_IDX);
  assign target_match = ((item.command_code == CMD_CIS) && (cal.target == TGT_CIS)) ||
                        ((item.command_code == CMD_CB) && (cal.target == TGT_CB));

  always_comb begin
    cal_next = cal;
    wr       = '0;
    wr.addr  = item.index_or_status - 8'd1;
    wr.data  = item.sample_value;
    rc       = RC_DONE;
    unique case (action_e'(item.action))
      ACT_REPLY: begin
        priority if (item.command_code == CMD_SENSOR) begin
          priority if (item.frame_length < SENSOR_MIN_LEN) begin
            rc = RC_INVALID;
          end else if (idx_zero) begin
            wr.clear = 1'b1;
            wr.bump  = 1'b1;
            rc       = RC_START;
          end else if (pair_end) begin
            rc = RC_END;
          end else if (idx_in_range) begin
            wr.write = 1'b1;
            wr.bump  = 1'b1;
            rc       = RC_DATA;
          end else begin
            rc = RC_IGNORED;
          end
        end else if ((item.command_code == CMD_CIS) || (item.command_code == CMD_CB)) begin
          priority if (item.frame_length < CALIB_MIN_LEN) begin
            rc = RC_INVALID;
          end else if (!cal.session || !target_match) begin
            rc = RC_IGNORED;
          end else if (cal.target == TGT_CB) begin
            rc = RC_CALIB;
            priority if (item.index_or_status == STAT_RUNNING) begin
              cal_next.cb = CB_RUNNING;
            end else if (item.index_or_status == STAT_SUCCESS) begin
              cal_next.cb = CB_SUCCESS;
            end else if (item.index_or_status == STAT_FAIL_IR) begin
              cal_next.cb = CB_FAIL_IR;
            end else begin
              rc = RC_IGNORED;
            end
          end else if ((item.index_or_status >= STAT_RUNNING) &&
                       (item.index_or_status <= STAT_FAIL_IR)) begin
            cal_next.cis = item.index_or_status[2:0];
            rc           = RC_CALIB;
          end else begin
            rc = RC_IGNORED;
          end
        end else begin
          rc = RC_INVALID;
        end
      end
      ACT_BEGIN: begin
        if ((item.begin_target != BEGIN_CIS && item.begin_target != BEGIN_CB) ||
            cal.cis == CIS_RUNNING || cal.cb == CB_RUNNING) begin
          rc = RC_BEGIN_NO;
        end else begin
          cal_next.target  = item.begin_target[0];
          cal_next.session = 1'b1;
          if (item.begin_target == BEGIN_CB) begin
            cal_next.cb = CB_RUNNING;
          end else begin
            cal_next.cis = CIS_RUNNING;
          end
          rc = RC_BEGIN_OK;
        end
      end
      ACT_END: begin
        if (cal.cis == CIS_RUNNING) begin
          cal_next.cis = CIS_IDLE;
        end
        if (cal.cb == CB_RUNNING) begin
          cal_next.cb = CB_IDLE;
        end
        cal_next.session = 1'b0;
        rc               = RC_DONE;
      end
      ACT_READ: begin
        rc = RC_DONE;
      end
      default: begin
        rc = RC_DONE;
      end
    endcase
  end

endmodule

@@ design/drct_store.sv @@
`timescale 1ns / 1ps

module drct_store import drct_pkg::*; #(
  parameter int unsigned CHANNELS = CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  store_wr_t   wr,
  input  logic [2:0]  rd_ch,
  output logic [15:0] tally,
  output logic [7:0]  rd_raw,
  output logic        rd_valid
);

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [7:0] CH_COUNT = 8'(CHANNELS);

  logic [7:0]          raw_mem [CHANNELS];
  logic [CHANNELS-1:0] valid_q;
  logic [CHANNELS-1:0] valid_next;
  logic [CHANNELS-1:0] written_q;
  logic [CHANNELS-1:0] written_next;
  logic [7:0]          rd_wide;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic                rd_in_range;
  logic                rd_hit;
  logic [7:0]          rd_data;

  assign rd_wide     = 8'(rd_ch);
  assign rd_idx      = rd_wide[IDX_W-1:0];
  assign wr_idx      = wr.addr[IDX_W-1:0];
  assign rd_in_range = rd_wide < CH_COUNT;

  always_comb begin
    valid_next   = valid_q;
    written_next = written_q;
    if (wr.clear) begin
      valid_next = '0;
    end
    if (wr.write) begin
      valid_next[wr_idx]   = 1'b1;
      written_next[wr_idx] = 1'b1;
    end
  end

  // Raw values: one write port, one registered read port with write bypass
  always_ff @(posedge clk) begin
    if (step) begin
      if (wr.write) begin
        raw_mem[wr_idx] <= wr.data;
      end
      if (wr.write && wr_idx == rd_idx) begin
        rd_data <= wr.data;
      end else begin
        rd_data <= raw_mem[rd_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q   <= '0;
      written_q <= '0;
      tally     <= '0;
      rd_hit    <= 1'b0;
      rd_valid  <= 1'b0;
    end else if (step) begin
      valid_q   <= valid_next;
      written_q <= written_next;
      if (wr.bump) begin
        tally <= tally + 16'd1;
      end
      rd_hit   <= rd_in_range && written_next[rd_idx];
      rd_valid <= rd_in_range && valid_next[rd_idx];
    end
  end

  // Never-written entries read as zero
  assign rd_raw = rd_hit ? rd_data : 8'd0;

  assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(tally))
    else $error("tally moved without a step");

  assert property (@(posedge clk) disable iff (rst)
    rd_valid |-> rd_hit)
    else $error("valid channel reads as never written");

  assert property (@(posedge clk) disable iff (rst)
    (step && wr.clear) |=> (valid_q == '0))
    else $error("start frame left valid bits set");

endmodule
